[sv/iis_pkg.sv]
// shared types and constants for the indirect insertion sort core
`default_nettype none

package iis_pkg;

  localparam int unsigned MaxItemsDefault = 16;
  localparam int unsigned KeyW            = 32;
  localparam int unsigned PosOutW         = 4;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic                   last_key;
  } iis_in_t;

  typedef struct packed {
    logic signed [KeyW-1:0] sorted_key;
    logic [PosOutW-1:0]     original_position;
    logic                   last_result;
    logic                   overflow;
  } iis_out_t;

  typedef struct packed {
    logic insert;
    logic drain;
  } iis_ctrl_t;

endpackage

`default_nettype wire

[sv/iis_cell.sv]
// one insertion cell: holds a key and its arrival position
`default_nettype none

module iis_cell #(
  parameter int unsigned PosW = 4
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  iis_pkg::iis_ctrl_t            ctrl_i,
  input  wire signed [iis_pkg::KeyW-1:0] new_key_i,
  input  wire [PosW-1:0]                new_pos_i,
  input  wire                           prev_ins_i,
  input  wire                           prev_valid_i,
  input  wire signed [iis_pkg::KeyW-1:0] prev_key_i,
  input  wire [PosW-1:0]                prev_pos_i,
  input  wire                           next_valid_i,
  input  wire signed [iis_pkg::KeyW-1:0] next_key_i,
  input  wire [PosW-1:0]                next_pos_i,
  output logic                          ins_o,
  output logic                          valid_o,
  output logic signed [iis_pkg::KeyW-1:0] key_o,
  output logic [PosW-1:0]               pos_o
);
  import iis_pkg::*;

  logic                   valid_q, valid_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic [PosW-1:0]        pos_q, pos_d;

  // new key goes before this entry only on strictly smaller key, keeps ties stable
  assign ins_o = !valid_q || (new_key_i < key_q);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    pos_d   = pos_q;
    if (ctrl_i.insert && ins_o) begin
      if (prev_ins_i) begin
        valid_d = prev_valid_i;
        key_d   = prev_key_i;
        pos_d   = prev_pos_i;
      end else begin
        valid_d = 1'b1;
        key_d   = new_key_i;
        pos_d   = new_pos_i;
      end
    end else if (ctrl_i.drain) begin
      valid_d = next_valid_i;
      key_d   = next_key_i;
      pos_d   = next_pos_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pos_q <= pos_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign pos_o   = pos_q;

endmodule

`default_nettype wire

[sv/indirect_insertion_sort_core.sv]
// top level of the indirect insertion sort core
`default_nettype none

// Sorts a batch of signed 32-bit keys in ascending order, stable for equal
// keys, and returns each key with its arrival position in the batch. Keys
// stream in at one per cycle: a row of MaxItems insertion cells places each
// arriving key in its sorted slot in the same cycle it is accepted. The key
// flagged last_key closes the batch; the cell row then shifts out one result
// per cycle toward the output while the consumer is ready, and no key is
// taken until the final result of the batch has been accepted. Keys beyond
// MaxItems are dropped and every result of that batch carries the overflow
// flag; a dropped key marked last still ends the batch.

module indirect_insertion_sort_core #(
  parameter int unsigned MaxItems = iis_pkg::MaxItemsDefault
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  iis_pkg::iis_in_t  in_data_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output iis_pkg::iis_out_t out_data_o
);
  import iis_pkg::*;

  localparam int unsigned PosW = $clog2(MaxItems);
  localparam int unsigned CntW = $clog2(MaxItems + 1);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;

  logic      in_acc, out_acc, full, last_out;
  iis_ctrl_t ctrl;

  logic                   cell_ins   [MaxItems];
  logic                   cell_valid [MaxItems];
  logic signed [KeyW-1:0] cell_key   [MaxItems];
  logic [PosW-1:0]        cell_pos   [MaxItems];

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = (state_q == ST_DRAIN);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign full        = (count_q == CntW'(MaxItems));
  assign last_out    = !cell_valid[1];

  assign ctrl.insert = in_acc && !full;
  assign ctrl.drain  = out_acc;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
          if (in_data_i.last_key) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc && last_out) begin
          state_d = ST_LOAD;
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  for (genvar i = 0; i < MaxItems; i++) begin : g_cell
    logic                   prev_ins, prev_valid, next_valid;
    logic signed [KeyW-1:0] prev_key, next_key;
    logic [PosW-1:0]        prev_pos, next_pos;

    if (i == 0) begin : g_head
      assign prev_ins   = 1'b0;
      assign prev_valid = 1'b0;
      assign prev_key   = '0;
      assign prev_pos   = '0;
    end else begin : g_body
      assign prev_ins   = cell_ins[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_key   = cell_key[i-1];
      assign prev_pos   = cell_pos[i-1];
    end

    if (i == MaxItems - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_key   = '0;
      assign next_pos   = '0;
    end else begin : g_inner
      assign next_valid = cell_valid[i+1];
      assign next_key   = cell_key[i+1];
      assign next_pos   = cell_pos[i+1];
    end

    iis_cell #(
      .PosW(PosW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_key_i   (in_data_i.key),
      .new_pos_i   (count_q[PosW-1:0]),
      .prev_ins_i  (prev_ins),
      .prev_valid_i(prev_valid),
      .prev_key_i  (prev_key),
      .prev_pos_i  (prev_pos),
      .next_valid_i(next_valid),
      .next_key_i  (next_key),
      .next_pos_i  (next_pos),
      .ins_o       (cell_ins[i]),
      .valid_o     (cell_valid[i]),
      .key_o       (cell_key[i]),
      .pos_o       (cell_pos[i])
    );
  end

  assign out_data_o.sorted_key        = cell_key[0];
  assign out_data_o.original_position = PosOutW'(cell_pos[0]);
  assign out_data_o.last_result       = last_out;
  assign out_data_o.overflow          = ovf_q;

endmodule

`default_nettype wire

[sv/iis_checker.sv]
// port-level checks for the indirect insertion sort core
`default_nettype none

module iis_checker #(
  parameter int unsigned MaxItems = iis_pkg::MaxItemsDefault
) (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_ready_o,
  input iis_pkg::iis_in_t  in_data_i,
  input wire               out_valid_o,
  input wire               out_ready_i,
  input iis_pkg::iis_out_t out_data_o
);
  import iis_pkg::*;

  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // loading and draining never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while results pending");

  // closing key starts the result stream
  a_drain_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.last_key |=> out_valid_o)
    else $error("no result after closing key");

  // final result returns the core to loading
  a_drain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_data_o.last_result |=> !out_valid_o && in_ready_o)
    else $error("core not ready after final result");

  // results within a batch come out in ascending key order
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_data_o.last_result |=>
      $signed(out_data_o.sorted_key) >= $signed($past(out_data_o.sorted_key)))
    else $error("results out of order");

endmodule

bind indirect_insertion_sort_core iis_checker #(.MaxItems(MaxItems)) u_iis_checker (.*);

`default_nettype wire

[tb/indirect_insertion_sort_core_tb.sv]
// testbench for indirect_insertion_sort_core: batch sort prediction and result scoreboard
`timescale 1ns / 100ps

module indirect_insertion_sort_core_tb;

  localparam int unsigned Capacity  = iis_pkg::MaxItemsDefault;
  localparam int unsigned KeyTarget = 430;
  localparam int unsigned HoldOff   = 400;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned DrainWait = 40;
  localparam int unsigned MaxPrints = 20;

  class sort_scoreboard;
    iis_pkg::iis_out_t  expected_q[$];
    logic signed [31:0] slot_key[Capacity];
    logic [3:0]         slot_pos[Capacity];
    int unsigned        fill;
    bit                 dropped;
    int unsigned        errors;

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      if (errors <= MaxPrints)
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    // stable insert into the running order, results released on the closing key
    task note_key(input iis_pkg::iis_in_t item);
      int j;
      logic signed [31:0] k;
      iis_pkg::iis_out_t res;
      k = $signed(item.key);
      if (fill < Capacity) begin
        j = fill;
        while (j > 0 && slot_key[j-1] > k) begin
          slot_key[j] = slot_key[j-1];
          slot_pos[j] = slot_pos[j-1];
          j--;
        end
        slot_key[j] = k;
        slot_pos[j] = 4'(fill);
        fill++;
      end else begin
        dropped = 1'b1;
      end
      if (item.last_key) begin
        for (int i = 0; i < fill; i++) begin
          res.sorted_key        = slot_key[i];
          res.original_position = slot_pos[i];
          res.last_result       = (i == fill - 1);
          res.overflow          = dropped;
          expected_q.push_back(res);
        end
        fill    = 0;
        dropped = 1'b0;
      end
    endtask

    task check_result(input iis_pkg::iis_out_t got);
      iis_pkg::iis_out_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result key", got.sorted_key, '0);
      end else begin
        want = expected_q.pop_front();
        if (got.sorted_key !== want.sorted_key)
          report("sorted_key", got.sorted_key, want.sorted_key);
        if (got.original_position !== want.original_position)
          report("original_position", 32'(got.original_position),
                 32'(want.original_position));
        if (got.last_result !== want.last_result)
          report("last_result", 32'(got.last_result), 32'(want.last_result));
        if (got.overflow !== want.overflow)
          report("overflow", 32'(got.overflow), 32'(want.overflow));
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready;
  iis_pkg::iis_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  iis_pkg::iis_out_t out_data;

  sort_scoreboard sb = new();
  int unsigned    keys_sent;
  int unsigned    results_seen;
  int unsigned    burst_left;
  int unsigned    idle_cycles;
  int unsigned    rx_mode;
  int unsigned    rx_span;
  int unsigned    rx_phase;
  bit             held_off;

  always #6 clk_i = ~clk_i;

  indirect_insertion_sort_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  function automatic iis_pkg::iis_in_t make_item(input logic [31:0] k, input bit last);
    iis_pkg::iis_in_t item;
    item.key      = k;
    item.last_key = last;
    return item;
  endfunction

  function automatic logic [31:0] random_key();
    logic [31:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: k = $urandom();
      4, 5, 6:    k = 32'($urandom_range(0, 16)) - 32'd8;
      7: begin
        case ($urandom_range(0, 3))
          0: k = 32'h7fff_ffff;
          1: k = 32'h8000_0000;
          2: k = 32'h0000_0000;
          default: k = 32'hffff_ffff;
        endcase
      end
      8: k = {1'b1, 31'($urandom())};
      default: k = {1'b0, 31'($urandom())};
    endcase
    return k;
  endfunction

  task automatic send_key(input iis_pkg::iis_in_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
    keys_sent++;
  endtask

  task automatic send_batch(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_key(make_item(random_key(), i == n - 1));
  endtask

  // monitor: inputs are noted before results are checked in the same cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready)
        sb.note_key(in_data);
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
        results_seen++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver with changing stall patterns and one long hold-off
  initial begin
    out_ready = 1'b0;
    rx_phase  = 0;
    held_off  = 1'b0;
    @(posedge rst_ni);
    forever begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(16, 96);
      repeat (rx_span) begin
        @(negedge clk_i);
        if (!held_off && results_seen >= 40) begin
          held_off = 1'b1;
          out_ready <= 1'b0;
          repeat (HoldOff) @(negedge clk_i);
        end
        rx_phase++;
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (rx_phase % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned pick;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    keys_sent   = 0;
    burst_left  = 0;
    idle_cycles = 0;
    results_seen = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // single key batch
    send_key(make_item(32'h7fff_ffff, 1'b1));
    // extremes and equal keys
    send_key(make_item(32'h7fff_ffff, 1'b0));
    send_key(make_item(32'h8000_0000, 1'b0));
    send_key(make_item(32'h0000_0000, 1'b0));
    send_key(make_item(32'hffff_ffff, 1'b0));
    send_key(make_item(32'h0000_0000, 1'b1));
    // descending over capacity, closing key dropped
    for (int i = 0; i < 18; i++)
      send_key(make_item(32'(1000 - i * 137), i == 17));

    while (keys_sent < KeyTarget) begin
      pick = $urandom_range(0, 19);
      if (pick < 14)
        n = $urandom_range(1, 6);
      else if (pick < 17)
        n = $urandom_range(7, 16);
      else if (pick == 17)
        n = Capacity;
      else
        n = $urandom_range(Capacity + 1, Capacity + 6);
      send_batch(n);
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[indirect_insertion_sort_core.f]
sv/iis_pkg.sv
sv/iis_cell.sv
sv/indirect_insertion_sort_core.sv
sv/iis_checker.sv
tb/indirect_insertion_sort_core_tb.sv
